// File: design/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ascii digit converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // width of the converted value
  localparam int VALUE_W = 32;

  // digit slots: octal needs the most digits of the three radices
  localparam int NUM_DIGITS = (VALUE_W + 2) / 3;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int DIGIT_W    = 4;
  localparam int EXT_W      = NUM_DIGITS * DIGIT_W;

  // decimal conversion: shift-and-add-3, a few value bits per cycle
  localparam int DD_BITS    = 4;
  localparam int DD_STEPS   = VALUE_W / DD_BITS;
  localparam int DD_STEP_W  = (DD_STEPS > 1) ? $clog2(DD_STEPS) : 1;

  // queue between front and back
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // ascii
  localparam int CHAR_W                      = 7;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] LOWER_HEX_GAP = 7'd39;
  localparam logic [CHAR_W-1:0] UPPER_HEX_GAP = 7'd7;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE   = 4'd9;

  // radix codes
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;

  // one queued conversion item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    radix_t             radix;
    logic               upper;
  } job_t;

  // converted digits handed to the emitter
  typedef struct packed {
    digits_t          digits;
    logic [IDX_W-1:0] top;
    logic             upper;
  } dset_t;

endpackage

`default_nettype wire

// File: design/itoa_in_if.sv
// ---------------------------------------------------------------------------
// itoa_in_if
// Input channel: one value with radix choice and letter-case flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itoa_in_if import itoa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [1:0]         radix_select;
  logic               upper_case;

  modport source (output valid, value, radix_select, upper_case, input ready);
  modport sink   (input valid, value, radix_select, upper_case, output ready);
endinterface

`default_nettype wire

// File: design/itoa_out_if.sv
// ---------------------------------------------------------------------------
// itoa_out_if
// Result channel: one ascii digit with a last-digit mark.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itoa_out_if import itoa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, digit_char, last_digit, input ready);
  modport sink   (input valid, digit_char, last_digit, output ready);
endinterface

`default_nettype wire

// File: design/integer_to_ascii_digits.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_digits
// Unsigned binary to ascii decimal, hex or octal digits, leading digit first.
// ---------------------------------------------------------------------------
// Each accepted item gives its digits one per output item, most significant
// first, with leading zeros suppressed and last_digit set on the final one;
// zero gives a single '0' and radix code 3 gives no output at all. The output
// side moves one digit per cycle while out_ch.ready is high, and an item has
// as many digits as its value needs (up to 11 for octal). Decimal items also
// pass through the shift-and-add-3 unit, which loads the value, takes 4
// value bits per cycle and then hands off the digit set, overlapped with the
// emission of the previous item; with items back to back the load of one
// shares a cycle with the hand-off of the one before. Hex and octal items skip
// the shift steps and go from load straight to hand-off. A two-entry queue
// sits between input and converter, and the output is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_digits import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_nempty;
  job_t  push_job;
  job_t  pop_job;
  logic  set_valid;
  logic  set_ready;
  dset_t set_data;

  // front: accept and classify
  itoa_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // queue between front and back
  itoa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nempty   (q_nempty),
    .pop_job  (pop_job)
  );

  // back: digit conversion
  itoa_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .res_valid (set_valid),
    .res_ready (set_ready),
    .res       (set_data)
  );

  // back: character output
  itoa_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .set_in    (set_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: design/itoa_front.sv
// ---------------------------------------------------------------------------
// itoa_front
// Accepts items, decodes the radix and drops items with an unused radix code.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_front import itoa_pkg::*; (
  itoa_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output job_t    q_job
);

  logic   radix_ok;
  radix_t radix;

  // classify the radix code
  always_comb begin
    radix    = radix_t'(in_ch.radix_select);
    radix_ok = (in_ch.radix_select == RADIX_DEC) ||
               (in_ch.radix_select == RADIX_HEX) ||
               (in_ch.radix_select == RADIX_OCT);
  end

  // accept whenever the queue has room; unused radix items end here
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && radix_ok;

  always_comb begin
    q_job.value = in_ch.value;
    q_job.radix = radix;
    q_job.upper = in_ch.upper_case;
  end

endmodule

`default_nettype wire

// File: design/itoa_queue.sv
// ---------------------------------------------------------------------------
// itoa_queue
// Short fifo of conversion items between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_queue import itoa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nempty,
  output job_t pop_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign nempty  = (cnt_r != '0);
  assign pop_job = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push ? QPTR_W'(1) : '0);
    rd_ptr_nxt = rd_ptr_r + (pop ? QPTR_W'(1) : '0);
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: design/itoa_conv.sv
// ---------------------------------------------------------------------------
// itoa_conv
// Turns a queued value into a digit vector: hex and octal by grouping bits,
// decimal by shift-and-add-3 over several cycles. Finds the leading digit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_conv import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_nempty,
  input  job_t  q_job,
  output logic  q_pop,
  output logic  res_valid,
  input  logic  res_ready,
  output dset_t res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [EXT_W-1:0]     bcd_r, bcd_nxt;
  logic [DD_STEP_W-1:0] step_r;
  radix_t               radix_r;
  logic                 upper_r;
  logic                 load;
  logic [EXT_W-1:0]     ext;
  digits_t              digs;
  logic [IDX_W-1:0]     top;

  // pop the next item when idle or when the finished set is taken
  assign load      = q_nempty && ((state_r == ST_IDLE) ||
                                  ((state_r == ST_DONE) && res_ready));
  assign q_pop     = load;
  assign res_valid = (state_r == ST_DONE);

  // several shift-and-add-3 steps per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int b = 0; b < DD_BITS; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_nxt[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_nxt[d*DIGIT_W +: DIGIT_W] = bcd_nxt[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[EXT_W-2:0], bin_nxt[VALUE_W-1]};
      bin_nxt = {bin_nxt[VALUE_W-2:0], 1'b0};
    end
  end

  // digit vector for the held radix
  always_comb begin
    ext = EXT_W'(bin_r);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      case (radix_r)
        RADIX_DEC: digs[i] = bcd_r[i*DIGIT_W +: DIGIT_W];
        RADIX_HEX: digs[i] = ext[i*DIGIT_W +: DIGIT_W];
        RADIX_OCT: digs[i] = {1'b0, ext[i*3 +: 3]};
        default:   digs[i] = '0;
      endcase
    end
  end

  // most significant nonzero digit, zero gives slot 0
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digs[i] != '0) begin
        top = IDX_W'(i);
      end
    end
  end

  always_comb begin
    res.digits = digs;
    res.top    = top;
    res.upper  = upper_r;
  end

  // conversion sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      if (load) begin
        bin_r   <= q_job.value;
        bcd_r   <= '0;
        step_r  <= '0;
        radix_r <= q_job.radix;
        upper_r <= q_job.upper;
        state_r <= (q_job.radix == RADIX_DEC) ? ST_SHIFT : ST_DONE;
      end else begin
        case (state_r)
          ST_IDLE: begin
            state_r <= ST_IDLE;
          end
          ST_SHIFT: begin
            bin_r  <= bin_nxt;
            bcd_r  <= bcd_nxt;
            step_r <= step_r + DD_STEP_W'(1);
            if (step_r == DD_STEP_W'(DD_STEPS - 1)) begin
              state_r <= ST_DONE;
            end
          end
          ST_DONE: begin
            if (res_ready) begin
              state_r <= ST_IDLE;
            end
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: design/itoa_emit.sv
// ---------------------------------------------------------------------------
// itoa_emit
// Walks a digit set from the leading digit down and drives one ascii
// character per item on the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_emit import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  set_valid,
  output logic  set_ready,
  input  dset_t set_in,
  itoa_out_if.source out_ch
);

  logic              slot_valid_r;
  digits_t           digs_r;
  logic [IDX_W-1:0]  idx_r;
  logic              upper_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              adv;
  logic              at_last;
  digit_t            cur;
  logic [CHAR_W-1:0] char_nxt;

  assign adv       = slot_valid_r && (!out_valid_r || out_ch.ready);
  assign at_last   = (idx_r == '0);
  assign set_ready = !slot_valid_r || (adv && at_last);

  // digit to ascii
  always_comb begin
    cur      = digs_r[idx_r];
    char_nxt = ASCII_ZERO + CHAR_W'(cur);
    if (cur > DIGIT_NINE) begin
      char_nxt = char_nxt + (upper_r ? UPPER_HEX_GAP : LOWER_HEX_GAP);
    end
  end

  // digit slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else begin
      if (set_valid && set_ready) begin
        slot_valid_r <= 1'b1;
        digs_r       <= set_in.digits;
        idx_r        <= set_in.top;
        upper_r      <= set_in.upper;
      end else if (adv) begin
        if (at_last) begin
          slot_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r - IDX_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        char_r      <= char_nxt;
        last_r      <= at_last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = char_r;
  assign out_ch.last_digit = last_r;

endmodule

`default_nettype wire

// File: tb/tb_integer_to_ascii_digits.sv
// ---------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Self-checking bench for the integer to ascii digit converter.
// ---------------------------------------------------------------------------
// A table of directed items walks zero, full-scale values, the radix
// boundaries, both letter cases and the unused radix code. A random run of
// about seventy converted items follows. Rows with an obvious answer carry
// it as text; every other item is checked against a digit predictor. Both
// channel sides idle at random; the sender waits for the output to drain
// after the directed table and again halfway through the random run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits;
  import itoa_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_ITEMS = 70;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         NUM_DIR      = 24;
  localparam logic [1:0] RADIX_NONE   = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_exp_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [1:0]         radix;
    logic               upper;
    bit                 typed;
    string              text;
  } dir_row_t;

  logic clk;
  logic rst_n;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   stall_left     = 0;
  bit   steady_ready   = 1'b0;

  digit_exp_t digit_expect_q [$];

  // directed items: value, radix, case flag, answer given, answer
  dir_row_t dir_rows [NUM_DIR] = '{
    '{32'd0,          RADIX_DEC,  1'b0, 1'b1, "0"},
    '{32'd0,          RADIX_HEX,  1'b1, 1'b1, "0"},
    '{32'd0,          RADIX_OCT,  1'b0, 1'b1, "0"},
    '{32'hFFFFFFFF,   RADIX_DEC,  1'b0, 1'b1, "4294967295"},
    '{32'hFFFFFFFF,   RADIX_HEX,  1'b0, 1'b1, "ffffffff"},
    '{32'hFFFFFFFF,   RADIX_HEX,  1'b1, 1'b1, "FFFFFFFF"},
    '{32'hFFFFFFFF,   RADIX_OCT,  1'b1, 1'b1, "37777777777"},
    '{32'hFFFFFFFF,   RADIX_NONE, 1'b0, 1'b1, ""},
    '{32'd0,          RADIX_NONE, 1'b1, 1'b1, ""},
    '{32'd9,          RADIX_DEC,  1'b0, 1'b1, "9"},
    '{32'd10,         RADIX_DEC,  1'b1, 1'b1, "10"},
    '{32'h0000000A,   RADIX_HEX,  1'b0, 1'b1, "a"},
    '{32'h0000000F,   RADIX_HEX,  1'b1, 1'b1, "F"},
    '{32'd7,          RADIX_OCT,  1'b1, 1'b1, "7"},
    '{32'd8,          RADIX_OCT,  1'b0, 1'b1, "10"},
    '{32'd1000000000, RADIX_DEC,  1'b0, 1'b1, "1000000000"},
    '{32'h10000000,   RADIX_HEX,  1'b0, 1'b1, "10000000"},
    '{32'o1000000000, RADIX_OCT,  1'b0, 1'b1, "1000000000"},
    '{32'd999999999,  RADIX_DEC,  1'b0, 1'b0, ""},
    '{32'hDEADBEEF,   RADIX_HEX,  1'b0, 1'b0, ""},
    '{32'hDEADBEEF,   RADIX_HEX,  1'b1, 1'b0, ""},
    '{32'hDEADBEEF,   RADIX_OCT,  1'b1, 1'b0, ""},
    '{32'h80000000,   RADIX_DEC,  1'b1, 1'b0, ""},
    '{32'h7FFFFFFF,   RADIX_OCT,  1'b0, 1'b0, ""}
  };

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  integer_to_ascii_digits dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 8);
    else return $urandom_range(15, 40);
  endfunction

  function automatic int sender_gap();
    if (steady_ready || $urandom_range(0, 1) == 0) return 0;
    return pick_gap();
  endfunction

  // values that hit digit boundaries more often than uniform draws would
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    int                 k;
    p = VALUE_W'(1);
    case ($urandom_range(0, 5))
      0: return VALUE_W'($urandom_range(0, 20));
      1: return {VALUE_W{1'b1}} >> $urandom_range(0, VALUE_W - 1);
      2: return (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1)) - VALUE_W'($urandom_range(0, 1));
      3: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * VALUE_W'(10);
        return p - VALUE_W'($urandom_range(0, 1));
      end
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // expected digits of one value, most significant first
  function automatic void push_digits(logic [VALUE_W-1:0] value, logic [1:0] radix,
                                      logic upper);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] base;
    digit_t             digs [NUM_DIGITS];
    int                 n;
    logic [CHAR_W-1:0]  c;
    case (radix)
      RADIX_DEC: base = VALUE_W'(10);
      RADIX_HEX: base = VALUE_W'(16);
      RADIX_OCT: base = VALUE_W'(8);
      default: return;
    endcase
    rest = value;
    n = 0;
    do begin
      digs[n] = digit_t'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      c = ASCII_ZERO + CHAR_W'(digs[k]);
      if (digs[k] > DIGIT_NINE) c = c + (upper ? UPPER_HEX_GAP : LOWER_HEX_GAP);
      digit_expect_q.push_back('{c, k == 0});
    end
  endfunction

  // expected digits given as text
  function automatic void push_text(string text);
    byte b;
    for (int i = 0; i < text.len(); i++) begin
      b = text.getc(i);
      digit_expect_q.push_back('{b[CHAR_W-1:0], i == text.len() - 1});
    end
  endfunction

  // offer one item after a gap, record its digits once accepted
  task automatic send_item(logic [VALUE_W-1:0] value, logic [1:0] radix, logic upper,
                           int gap, bit typed, string text);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.value        <= value;
    in_ch.radix_select <= radix;
    in_ch.upper_case   <= upper;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) push_text(text);
    else push_digits(value, radix, upper);
  endtask

  // stop sending until every digit has come out
  task automatic hold_off();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digit_expect_q.size() != 0) @(posedge clk);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (steady_ready) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 20) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each output item with the oldest expected digit
  always @(posedge clk) begin
    digit_exp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digit_expect_q.size() == 0) begin
        $display("%0t: unexpected digit: expected none, got char %h last %b",
                 $time, out_ch.digit_char, out_ch.last_digit);
        mismatch_count++;
      end else begin
        want = digit_expect_q.pop_front();
        if (out_ch.digit_char !== want.digit_char) begin
          $display("%0t: digit_char mismatch: expected %h, got %h",
                   $time, want.digit_char, out_ch.digit_char);
          mismatch_count++;
        end
        if (out_ch.last_digit !== want.last_digit) begin
          $display("%0t: last_digit mismatch: expected %b, got %b",
                   $time, want.last_digit, out_ch.last_digit);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int         counted;
    logic [1:0] radix;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.value        = '0;
    in_ch.radix_select = RADIX_DEC;
    in_ch.upper_case   = 1'b0;
    out_ch.ready       = 1'b0;
    counted            = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      send_item(dir_rows[i].value, dir_rows[i].radix, dir_rows[i].upper, sender_gap(),
                dir_rows[i].typed, dir_rows[i].text);
    end
    hold_off();

    // random items, unused radix code mixed in as noise
    while (counted < RANDOM_ITEMS) begin
      radix = ($urandom_range(0, 99) < 8) ? RADIX_NONE : 2'($urandom_range(0, 2));
      if (radix != RADIX_NONE) begin
        counted++;
        if (counted == RANDOM_ITEMS / 2) hold_off();
      end
      steady_ready = (counted >= 50 && counted < 65);
      send_item(pick_value(), radix, 1'($urandom_range(0, 1)), sender_gap(), 1'b0, "");
    end
    steady_ready = 1'b0;

    // drain and report
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digit_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
